// ----- rtl/gpc_pkg.sv -----
// Goldbach pair counter: shared widths and defaults.
// No dependencies.
package gpc_pkg;
	localparam int NumWidthDef   = 16;
	localparam int TableDepthDef = 8192;
	localparam int PairW         = 13;
	localparam int PrimeW        = 14;
	localparam logic [PairW-1:0] PairMax = '1;
endpackage

// ----- rtl/gpc_if.sv -----
// Valid/ready channel interfaces for the Goldbach pair counter.
// Depends on gpc_pkg.
interface gpc_in_if;
	logic        valid;
	logic        ready;
	logic [15:0] n;
	modport source (output valid, n, input ready);
	modport sink   (input valid, n, output ready);
endinterface

interface gpc_out_if;
	logic                      valid;
	logic                      ready;
	logic [gpc_pkg::PairW-1:0]  pair_count;
	logic [gpc_pkg::PrimeW-1:0] prime_count;
	logic                      invalid;
	modport source (output valid, pair_count, prime_count, invalid, input ready);
	modport sink   (input valid, pair_count, prime_count, invalid, output ready);
endinterface

// ----- rtl/gpc_divider.sv -----
// Iterative remainder unit: one quotient bit per cycle, reports zero remainder.
// No dependencies.
module gpc_divider #(
	parameter int W = 16
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	input  logic [W-1:0] dividend,
	input  logic [W-1:0] divisor,
	output logic         done,
	output logic         divides
);
	localparam int CW = $clog2(W + 1);
	logic [W-1:0]  rem_q;
	logic [W-1:0]  quo_q;
	logic [W-1:0]  dvs_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q;
	logic [W:0]    trial;

	assign trial = {rem_q, quo_q[W-1]} - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done   <= 1'b0;
			cnt_q  <= '0;
			rem_q  <= '0;
			quo_q  <= '0;
			dvs_q  <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(W);
				rem_q  <= '0;
				quo_q  <= dividend;
				dvs_q  <= divisor;
			end else if (busy_q) begin
				// shift one dividend bit into the partial remainder
				if (!trial[W]) rem_q <= trial[W-1:0];
				else           rem_q <= {rem_q[W-2:0], quo_q[W-1]};
				quo_q <= {quo_q[W-2:0], 1'b0};
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end

	assign divides = (rem_q == '0);

	property p_done_after_busy;
		@(posedge clk) disable iff (!arst_n) done |-> $past(busy_q);
	endproperty
	a_done_after_busy: assert property (p_done_after_busy) else $error("done without work");
	a_no_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> !busy_q) else $error("start while busy");
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy_q) else $error("done while still busy");
endmodule

// ----- rtl/goldbach_pair_counter.sv -----
// Goldbach pair counter top level: sieve by trial division into a prime
// table memory, then a two-pointer walk. Depends on gpc_pkg, gpc_if, gpc_divider.
//
// Usage: one beat on in_ch carries n; one beat on out_ch returns pair_count,
// prime_count and invalid. The block works on one number at a time: in_ch.ready
// is high only while idle with no result held. An odd n or n <= 2 goes
// through S_OUT, which raises out_ch.valid with invalid set.
// Otherwise every odd candidate c <= n is tested against odd divisors d with
// d*d <= c; each test is a bound check (S_WAIT), a start (S_DIV) and a wait
// on the remainder unit (S_DIVWAIT). A prime c needs about sqrt(c)/2
// tests; a composite stops at its smallest factor. Each walk step is two
// registered memory reads and a compare (S_WSTART, S_READ, S_CMP), for at
// most primes_found steps. Reset clears the control and result registers;
// the read data registers and the table memory are not cleared, the table
// is written before it is read. A stalled out_ch holds the result register;
// the next beat is accepted once the result has been taken.
module goldbach_pair_counter #(
	parameter int NUM_WIDTH   = gpc_pkg::NumWidthDef,
	parameter int TABLE_DEPTH = gpc_pkg::TableDepthDef
) (
	input logic clk,
	input logic arst_n,
	gpc_in_if.sink    in_ch,
	gpc_out_if.source out_ch
);
	import gpc_pkg::*;

	localparam int AW = $clog2(TABLE_DEPTH);
	localparam int CW = $clog2(TABLE_DEPTH + 1);
	localparam int W  = NUM_WIDTH;

	typedef enum logic [3:0] {
		S_IDLE, S_CAND, S_DIV, S_DIVWAIT, S_WAIT, S_STORE, S_WSTART, S_READ, S_CMP,
		S_OUT
	} state_t;

	state_t        state_q;
	logic [W-1:0]  n_q;
	logic [W-1:0]  cand_q;
	logic [W-1:0]  div_q;
	logic [CW-1:0] found_q;
	logic [AW+1:0] lo_q;
	logic [AW+1:0] hi_q;
	logic [PairW-1:0] sol_q;
	logic          valid_q;
	logic [PairW-1:0]  pair_q;
	logic [PrimeW-1:0] pcnt_q;
	logic          inv_q;

	logic [W-1:0]  mem [TABLE_DEPTH];
	logic          wr_en;
	logic [AW-1:0] wr_addr;
	logic [W-1:0]  wr_data;
	logic [AW-1:0] rd_addr;
	logic [W-1:0]  rd_data_q;

	logic          dv_start, dv_done, dv_divides;
	logic [2*W-1:0] sq;
	logic [W:0]    sum;
	logic [W-1:0]  nin;

	assign nin = W'(in_ch.n);
	assign sq  = div_q * div_q;

	gpc_divider #(.W(W)) u_div (
		.clk, .arst_n, .start(dv_start), .dividend(cand_q), .divisor(div_q),
		.done(dv_done), .divides(dv_divides)
	);

	// single memory port pair: one write, one registered read
	always_ff @(posedge clk) begin
		if (wr_en) mem[wr_addr] <= wr_data;
		rd_data_q <= mem[rd_addr];
	end

	logic [W-1:0] lo_val_q;

	assign in_ch.ready = (state_q == S_IDLE) && !valid_q;
	assign dv_start    = (state_q == S_DIV);
	assign wr_en       = (state_q == S_STORE) && (found_q < CW'(TABLE_DEPTH));
	assign wr_addr     = found_q[AW-1:0];
	assign wr_data     = cand_q;
	// low entry is read from S_WSTART, high entry from S_READ
	assign rd_addr     = (state_q == S_READ) ? hi_q[AW-1:0] : lo_q[AW-1:0];
	assign sum         = {1'b0, lo_val_q} + {1'b0, rd_data_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			valid_q <= 1'b0;
			n_q     <= '0;
			cand_q  <= '0;
			div_q   <= '0;
			found_q <= '0;
			lo_q    <= '0;
			hi_q    <= '0;
			sol_q   <= '0;
			pair_q  <= '0;
			pcnt_q  <= '0;
			inv_q   <= 1'b0;
		end else begin
			if (valid_q && out_ch.ready) valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (in_ch.valid && in_ch.ready) begin
						n_q <= nin;
						if (nin[0] || nin <= W'(2)) begin
							pair_q  <= '0;
							pcnt_q  <= '0;
							inv_q   <= 1'b1;
							state_q <= S_OUT;
						end else begin
							// store 2 first, then odd candidates from 3
							cand_q  <= W'(2);
							found_q <= '0;
							state_q <= S_STORE;
						end
					end
				end
				S_CAND: begin
					if ({1'b0, cand_q} > {1'b0, n_q}) begin
						sol_q   <= '0;
						lo_q    <= '0;
						hi_q    <= (AW+2)'(found_q) - 1'b1;
						state_q <= S_WSTART;
					end else begin
						div_q   <= W'(3);
						state_q <= S_WAIT;
					end
				end
				S_WAIT: begin
					// d*d > c: no divisor left, c is prime
					if (sq > (2*W)'(cand_q)) state_q <= S_STORE;
					else                     state_q <= S_DIV;
				end
				S_DIV: state_q <= S_DIVWAIT;
				S_DIVWAIT: begin
					if (dv_done) begin
						if (dv_divides) begin
							cand_q  <= cand_q + W'(2);
							state_q <= S_CAND;
						end else begin
							div_q   <= div_q + W'(2);
							state_q <= S_WAIT;
						end
					end
				end
				S_STORE: begin
					if (found_q < CW'(TABLE_DEPTH)) found_q <= found_q + 1'b1;
					cand_q  <= (cand_q == W'(2)) ? W'(3) : cand_q + W'(2);
					state_q <= S_CAND;
				end
				S_WSTART: begin
					if ($signed(lo_q) > $signed(hi_q)) begin
						pair_q  <= sol_q;
						pcnt_q  <= PrimeW'(found_q);
						inv_q   <= 1'b0;
						state_q <= S_OUT;
					end else begin
						state_q <= S_READ;
					end
				end
				S_READ: begin
					// low entry arrives now; fetch high entry
					state_q <= S_CMP;
				end
				S_CMP: begin
					if (sum == {1'b0, n_q}) begin
						if (sol_q != PairMax) sol_q <= sol_q + 1'b1;
						lo_q    <= lo_q + 1'b1;
						hi_q    <= hi_q - 1'b1;
						state_q <= S_WSTART;
					end else if (sum < {1'b0, n_q}) begin
						lo_q    <= lo_q + 1'b1;
						state_q <= S_WSTART;
					end else begin
						hi_q    <= hi_q - 1'b1;
						state_q <= S_WSTART;
					end
				end
				S_OUT: begin
					valid_q <= 1'b1;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// lo entry latched from the read data register while in S_READ
	always_ff @(posedge clk) begin
		if (state_q == S_READ) lo_val_q <= rd_data_q;
	end

	assign out_ch.valid       = valid_q;
	assign out_ch.pair_count  = pair_q;
	assign out_ch.prime_count = pcnt_q;
	assign out_ch.invalid     = inv_q;

	a_ready_idle: assert property (@(posedge clk) disable iff (!arst_n)
		in_ch.ready |-> !dv_done) else $error("divider active while idle");
	a_inv_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_ch.valid && out_ch.invalid) |-> (out_ch.pair_count == '0))
		else $error("invalid result with pairs");
	a_write_bound: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> (found_q < CW'(TABLE_DEPTH))) else $error("table overrun");
endmodule
